### rtl/kda_pkg.sv
`default_nettype none

package kda_pkg;

	// matrix geometry
	localparam int MAX_ROWS     = 8;
	localparam int MAX_COLS     = 8;
	localparam int DEF_ROWS     = 8;
	localparam int DEF_COLS     = 8;
	localparam int LEVEL_W      = MAX_ROWS * MAX_COLS;
	localparam int KEY_W        = 6;
	localparam int IDX_W        = 3;
	localparam int TIME_W       = 32;
	localparam int CFG_W        = 16;
	localparam int CFG_IDX_W    = 2;

	// scan modes
	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_DEBOUNCE = 2'd1;
	localparam logic [1:0] MODE_PRESSED  = 2'd2;
	localparam logic [1:0] MODE_HOLD     = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_REPEAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTV  = 2'd2;

	// register reset values
	localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd10;
	localparam logic [CFG_W-1:0] RST_FIRST_REPEAT = 16'd500;
	localparam logic [CFG_W-1:0] RST_REPEAT_INTV  = 16'd100;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [TIME_W-1:0] stamp_t;

endpackage

`default_nettype wire

### rtl/keypad_debounce_autorepeat.sv
`default_nettype none

// keypad scanner with debounce and auto-repeat
//
// in channel (in_valid/in_ready): one transaction is one snapshot of the key
// matrix (key_levels, active low, bit row*8+column) plus the ms timestamp now_ms.
// out channel (out_valid/out_ready): exactly one result transaction per input
// transaction, key_valid high when a press or a repeat is reported, with
// key_row/key_column of the tracked key (both zero when nothing is reported).
// cfg port: cfg_write/cfg_index/cfg_data writes debounce, first repeat and
// repeat interval times; write only while no transaction is in flight.
// path: input register, then one pass of priority encode, 32-bit
// subtract/compare and state update into the result register.
// throughput: one transaction per cycle while results are taken, bounded by
// the update of the tracked-key state that each snapshot reads and writes.
// stall: a waiting result holds the result register; the input register
// still takes one more transaction, then in_ready drops until out_ready.
// reset: mode idle, tracked key and time mark zero, registers at their
// default times, both pipeline registers empty.

module keypad_debounce_autorepeat
	import kda_pkg::*;
#(
	parameter int ROWS = DEF_ROWS,
	parameter int COLS = DEF_COLS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// input channel
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [LEVEL_W-1:0]   key_levels,
	input  wire logic [TIME_W-1:0]    now_ms,
	// result channel
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      key_valid,
	output logic [IDX_W-1:0]          key_row,
	output logic [IDX_W-1:0]          key_column,
	// configuration
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// configuration registers
	logic [CFG_W-1:0] debounce_q;
	logic [CFG_W-1:0] first_repeat_q;
	logic [CFG_W-1:0] repeat_intv_q;

	// tracking state
	logic [1:0] mode_q;
	key_t       held_q;
	stamp_t     mark_q;

	// input register
	logic               valid_s1;
	logic [LEVEL_W-1:0] levels_s1;
	stamp_t             now_s1;

	// result register
	logic             out_valid_q;
	logic             key_valid_q;
	logic [IDX_W-1:0] key_row_q;
	logic [IDX_W-1:0] key_column_q;

	logic advance;

	// the result register frees up when empty or taken this cycle
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q     <= RST_DEBOUNCE;
			first_repeat_q <= RST_FIRST_REPEAT;
			repeat_intv_q  <= RST_REPEAT_INTV;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEBOUNCE:     debounce_q     <= cfg_data;
				REG_FIRST_REPEAT: first_repeat_q <= cfg_data;
				REG_REPEAT_INTV:  repeat_intv_q  <= cfg_data;
				default: ;  // writes beyond the register list are dropped
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			levels_s1 <= key_levels;
			now_s1    <= now_ms;
		end
	end

	// first pressed key in row-major order, only inside the scanned area
	logic [LEVEL_W-1:0] pressed;
	logic               found;
	key_t               key;

	always_comb begin
		for (int b = 0; b < LEVEL_W; b++) begin
			pressed[b] = !levels_s1[b] && ((b / MAX_COLS) < ROWS) && ((b % MAX_COLS) < COLS);
		end
		found = |pressed;
		key   = '0;
		// scan downward so the lowest pressed bit wins
		for (int b = LEVEL_W - 1; b >= 0; b--) begin
			if (pressed[b]) begin
				key = KEY_W'(b);
			end
		end
	end

	// elapsed time against the limit of the current mode
	logic [CFG_W-1:0] limit;
	logic [1:0]       next_on_hit;
	stamp_t           elapsed;
	logic             hit;

	always_comb begin
		unique case (mode_q)
			MODE_DEBOUNCE: begin
				limit       = debounce_q;
				next_on_hit = MODE_PRESSED;
			end
			MODE_PRESSED: begin
				limit       = first_repeat_q;
				next_on_hit = MODE_HOLD;
			end
			MODE_HOLD: begin
				limit       = repeat_intv_q;
				next_on_hit = MODE_HOLD;
			end
			default: begin
				limit       = '0;
				next_on_hit = MODE_IDLE;
			end
		endcase
		elapsed = now_s1 - mark_q;  // modular difference
		hit     = elapsed >= {{(TIME_W-CFG_W){1'b0}}, limit};
	end

	// next state and report
	logic [1:0] mode_d;
	key_t       held_d;
	stamp_t     mark_d;
	logic       report;

	always_comb begin
		mode_d = mode_q;
		held_d = held_q;
		mark_d = mark_q;
		report = 1'b0;
		if (!found) begin
			// release keeps key and mark
			mode_d = MODE_IDLE;
		end else if (mode_q == MODE_IDLE) begin
			mode_d = MODE_DEBOUNCE;
			held_d = key;
			mark_d = now_s1;
		end else if (key != held_q) begin
			// different key: back to idle, new key debounces on a later scan
			mode_d = MODE_IDLE;
		end else if (hit) begin
			mode_d = next_on_hit;
			mark_d = now_s1;
			report = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			held_q <= '0;
			mark_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			held_q <= held_d;
			mark_q <= mark_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_valid_q  <= report;
			key_row_q    <= report ? held_q[KEY_W-1:IDX_W] : '0;
			key_column_q <= report ? held_q[IDX_W-1:0] : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_valid  = key_valid_q;
	assign key_row    = key_row_q;
	assign key_column = key_column_q;

endmodule

`default_nettype wire

### rtl/kda_checker.sv
`default_nettype none

module kda_assertions
	import kda_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic             key_valid,
	input wire logic [IDX_W-1:0] key_row,
	input wire logic [IDX_W-1:0] key_column
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_valid)
			&& $stable(key_row) && $stable(key_column))
		else $error("stalled result changed");

	// a result without a report carries a zero key position
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_valid |-> key_row == '0 && key_column == '0)
		else $error("silent result with nonzero key");

	// an accepted transaction is followed by a valid result on the output
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> ##1 out_valid)
		else $error("result missing after input transaction");

	// with the result side empty the input side never stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind keypad_debounce_autorepeat kda_assertions u_kda_assertions (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.key_valid  (key_valid),
	.key_row    (key_row),
	.key_column (key_column)
);

`default_nettype wire
